// ----- rtl/tdma_arb_pkg.sv -----
// Shared types, register indexes and address map for the TDMA bus arbiter.
// Used by tdma_shared_bus_arbiter_unit and its bench; depends on nothing else.
package tdma_arb_pkg;

   // Default number of requester counters held by the arbiter
   localparam int MAX_REQUESTERS_DEF = 8;

   // Field widths fixed by the interface
   localparam int REQUESTER_W = 3;
   localparam int ADDRESS_W   = 32;
   localparam int COUNT_W     = 4;
   localparam int LAT_W       = 16;
   localparam int REMAIN_W    = LAT_W + 1;
   localparam int CSR_ADDR_W  = 3;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 8;
   localparam int LAT_REGS    = 6;

   // Address map
   localparam logic [ADDRESS_W-1:0] DDR_LO    = 32'h8000_0000;
   localparam logic [ADDRESS_W-1:0] DDR_HI    = 32'h83FF_FFFF;
   localparam logic [ADDRESS_W-1:0] ONCHIP_LO = 32'h8539_0000;
   localparam logic [ADDRESS_W-1:0] ONCHIP_HI = 32'h8548_FFFF;
   localparam logic [ADDRESS_W-1:0] SRAM_LO   = 32'h8630_0000;
   localparam logic [ADDRESS_W-1:0] SRAM_HI   = 32'h863F_FFFF;

   // Idle marker of a requester's remaining count
   localparam logic [REMAIN_W-1:0] REMAIN_IDLE = '1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_REQ_COUNT   = 3'd0,
      CSR_SLOT_LEN    = 3'd1,
      CSR_LD_DDR      = 3'd2,
      CSR_LD_ONCHIP   = 3'd3,
      CSR_LD_SRAM     = 3'd4,
      CSR_ST_DDR      = 3'd5,
      CSR_ST_ONCHIP   = 3'd6,
      CSR_ST_SRAM     = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      REGION_DDR    = 2'd0,
      REGION_ONCHIP = 2'd1,
      REGION_SRAM   = 2'd2,
      REGION_NONE   = 2'd3
   } region_type;

   // Decode a byte address into its memory region
   function automatic region_type region_of(input logic [ADDRESS_W-1:0] addr);
      region_type r;
      r = REGION_NONE;
      if (addr >= DDR_LO && addr <= DDR_HI) begin
         r = REGION_DDR;
      end else if (addr >= ONCHIP_LO && addr <= ONCHIP_HI) begin
         r = REGION_ONCHIP;
      end else if (addr >= SRAM_LO && addr <= SRAM_HI) begin
         r = REGION_SRAM;
      end
      return r;
   endfunction

endpackage

// ----- rtl/tdma_shared_bus_arbiter_unit.sv -----
// TDMA shared bus arbiter: slot rotation, per-requester latency counters.
// Depends on tdma_arb_pkg for register indexes, widths and the address map.
//
//  channel | dir | handshake        | beat contents
//  req     | in  | tvalid / tready  | tuser: mode; tdata: requester, address, is_load
//  rsp     | out | tvalid / tready  | tdata: busy_res, unmapped, slot_owner
//  csr     | in  | wr_en, no wait   | addr: register index; wdata: value
//
// One beat per cycle sustained while the result is not stalled; a taken beat
// passes through the input register, then the result register, where its
// result is presented. The single read-modify-write of the owner's counter
// happens between those two registers.
// Reset (synchronous) idles every requester, hands the slot to requester 0
// and sets every register to 1. A stalled result holds the result register;
// the input register still takes one more beat behind it.
module tdma_shared_bus_arbiter_unit
   import tdma_arb_pkg::*;
#(
   parameter int MAX_REQUESTERS = MAX_REQUESTERS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // Request channel
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_TDATA_W-1:0]  req_tdata,   // [2:0] requester, [34:3] address,
                                                // [35] is_load, [39:36] zero
   input  logic                    req_tuser,   // [0] mode: 0 tick, 1 busy query
   // Result channel
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,   // [0] busy_res, [1] unmapped,
                                                // [4:2] slot_owner, [7:5] zero
   // Register write port
   input  logic                    csr_wr_en,
   input  logic [CSR_ADDR_W-1:0]   csr_addr,
   input  logic [LAT_W-1:0]        csr_wdata
);

   localparam int OW   = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
   localparam int CW   = $clog2(MAX_REQUESTERS + 1);
   localparam int NW   = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int CMPW = (OW > REQUESTER_W) ? OW : REQUESTER_W;

   // Next owner in rotation: (nxt mod n), nxt and n both small
   function automatic logic [OW-1:0] wrap_owner(input logic [OW:0] nxt,
                                                input logic [NW-1:0] n);
      int q;
      q = 0;
      for (int k = 1; k <= MAX_REQUESTERS; k++) begin
         if (k * int'(n) <= int'(nxt)) begin
            q = k;
         end
      end
      return OW'(int'(nxt) - q * int'(n));
   endfunction

   // Configuration registers
   logic [COUNT_W-1:0]   req_count_ff;
   logic [LAT_W-1:0]     slot_len_ff;
   logic [LAT_W-1:0]     lat_cfg_ff [LAT_REGS];

   // Arbiter state
   logic [REMAIN_W-1:0]  remain_ff [MAX_REQUESTERS];
   logic [REMAIN_W-1:0]  remain_in [MAX_REQUESTERS];
   logic [OW-1:0]        owner_ff, owner_in;
   logic [LAT_W-1:0]     slot_left_ff, slot_left_in;
   logic [LAT_W-1:0]     last_lat_ff, last_lat_in;

   // Input register
   logic                    in_valid_ff, in_valid_in;
   logic                    in_mode_ff;
   logic [REQUESTER_W-1:0]  in_req_ff;
   logic [ADDRESS_W-1:0]    in_addr_ff;
   logic                    in_load_ff;

   // Result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_busy_ff, rsp_busy_in;
   logic                    rsp_unm_ff, rsp_unm_in;
   logic [REQUESTER_W-1:0]  rsp_owner_ff, rsp_owner_in;

   logic                    fire;
   logic                    req_take;
   logic [NW-1:0]           n_active;
   logic [OW+REQUESTER_W-1:0] owner_ext;

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   // Clamp the requester count to the counters present
   always_comb begin
      if (NW'(req_count_ff) > NW'(MAX_REQUESTERS)) begin
         n_active = NW'(MAX_REQUESTERS);
      end else begin
         n_active = NW'(req_count_ff);
      end
   end

   // Process one beat against the owner's counter
   always_comb begin
      logic [REMAIN_W-1:0] cur;
      logic [REMAIN_W-1:0] cur_dec;
      logic [LAT_W-1:0]    lat_sel;
      logic [LAT_W-1:0]    slot_base;
      region_type          region;
      logic [OW-1:0]       owner_nxt;

      remain_in    = remain_ff;
      owner_in     = owner_ff;
      slot_left_in = slot_left_ff;
      last_lat_in  = last_lat_ff;
      rsp_busy_in  = rsp_busy_ff;
      rsp_unm_in   = rsp_unm_ff;
      owner_nxt    = owner_ff;
      cur          = remain_ff[owner_ff];
      cur_dec      = cur;
      slot_base    = slot_left_ff;
      region       = region_of(in_addr_ff);
      lat_sel      = '0;

      unique case (region)
         REGION_DDR:    lat_sel = in_load_ff ? lat_cfg_ff[0] : lat_cfg_ff[3];
         REGION_ONCHIP: lat_sel = in_load_ff ? lat_cfg_ff[1] : lat_cfg_ff[4];
         REGION_SRAM:   lat_sel = in_load_ff ? lat_cfg_ff[2] : lat_cfg_ff[5];
         REGION_NONE:   lat_sel = '0;
         default:       lat_sel = '0;
      endcase

      if (fire) begin
         rsp_busy_in = 1'b1;
         rsp_unm_in  = 1'b0;
         if (!in_mode_ff) begin
            // Tick: count down owner, then close the slot when it runs out
            rsp_busy_in = 1'b0;
            if ($signed(cur) > 0) begin
               cur_dec = cur - 1'b1;
            end
            remain_in[owner_ff] = cur_dec;
            if (slot_left_ff == '0) begin
               slot_base = slot_len_ff;
               if (n_active > NW'(1)) begin
                  if (cur_dec != REMAIN_IDLE) begin
                     remain_in[owner_ff] = {1'b0, last_lat_ff};
                  end
                  owner_nxt = wrap_owner({1'b0, owner_ff} + 1'b1, n_active);
                  owner_in  = owner_nxt;
               end
            end
            slot_left_in = slot_base - 1'b1;
         end else if (CMPW'(in_req_ff) == CMPW'(owner_ff)) begin
            // Query from the owner
            priority if (cur == '0) begin
               remain_in[owner_ff] = REMAIN_IDLE;
               rsp_busy_in         = 1'b0;
            end else if (cur != REMAIN_IDLE) begin
               rsp_busy_in = 1'b1;
            end else if (region == REGION_NONE) begin
               rsp_unm_in = 1'b1;
            end else begin
               remain_in[owner_ff] = {1'b0, lat_sel} - 1'b1;
               last_lat_in         = lat_sel - 1'b1;
            end
         end
      end
   end

   assign owner_ext    = {{REQUESTER_W{1'b0}}, owner_in};
   assign rsp_owner_in = fire ? owner_ext[REQUESTER_W-1:0] : rsp_owner_ff;

   // Handshake next values
   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         owner_ff     <= '0;
         slot_left_ff <= '0;
         last_lat_ff  <= '0;
         for (int i = 0; i < MAX_REQUESTERS; i++) begin
            remain_ff[i] <= REMAIN_IDLE;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         owner_ff     <= owner_in;
         slot_left_ff <= slot_left_in;
         last_lat_ff  <= last_lat_in;
         remain_ff    <= remain_in;
      end
   end

   // Payload registers: capture request beat, hold result beat
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff <= req_tuser;
         in_req_ff  <= req_tdata[2:0];
         in_addr_ff <= req_tdata[34:3];
         in_load_ff <= req_tdata[35];
      end
      rsp_busy_ff  <= rsp_busy_in;
      rsp_unm_ff   <= rsp_unm_in;
      rsp_owner_ff <= rsp_owner_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         req_count_ff <= COUNT_W'(1);
         slot_len_ff  <= LAT_W'(1);
         for (int i = 0; i < LAT_REGS; i++) begin
            lat_cfg_ff[i] <= LAT_W'(1);
         end
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_addr))
            CSR_REQ_COUNT: req_count_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_SLOT_LEN:  slot_len_ff   <= csr_wdata;
            CSR_LD_DDR:    lat_cfg_ff[0] <= csr_wdata;
            CSR_LD_ONCHIP: lat_cfg_ff[1] <= csr_wdata;
            CSR_LD_SRAM:   lat_cfg_ff[2] <= csr_wdata;
            CSR_ST_DDR:    lat_cfg_ff[3] <= csr_wdata;
            CSR_ST_ONCHIP: lat_cfg_ff[4] <= csr_wdata;
            CSR_ST_SRAM:   lat_cfg_ff[5] <= csr_wdata;
            default:       req_count_ff  <= req_count_ff;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_owner_ff, rsp_unm_ff, rsp_busy_ff};

endmodule

// ----- tb/tb_tdma_shared_bus_arbiter_unit.sv -----
`timescale 1ns / 100ps
// Self-checking bench for tdma_shared_bus_arbiter_unit: directed and random ticks and queries.
// Depends on tdma_arb_pkg for widths, register indexes and the address map.
module tb_tdma_shared_bus_arbiter_unit;
   import tdma_arb_pkg::*;

   localparam int SLOTS      = MAX_REQUESTERS_DEF;
   localparam int IDLE_LIMIT = 4000;

   typedef enum logic {
      BEAT_TICK  = 1'b0,
      BEAT_QUERY = 1'b1
   } beat_kind_type;

   // Reply layout, lowest bit last
   typedef struct packed {
      logic [REQUESTER_W-1:0] owner;
      logic                   unmapped;
      logic                   busy;
   } bus_reply_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // [2:0] requester, [34:3] address, [35] is_load
   logic                   req_tuser;   // [0] mode
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // [0] busy_res, [1] unmapped, [4:2] slot_owner
   logic                   csr_wr_en;
   logic [CSR_ADDR_W-1:0]  csr_addr;
   logic [LAT_W-1:0]       csr_wdata;

   // Arbiter shadow: registers, per-requester counts and slot state
   logic [LAT_W-1:0]           csr_shadow [8];
   logic [LAT_W-1:0]           staged_regs [8];
   logic signed [REMAIN_W-1:0] owed [SLOTS];
   int                         slot_holder;
   logic [LAT_W-1:0]           ticks_left;
   logic [LAT_W-1:0]           reload_ticks;

   bus_reply_type pending_replies [$];
   int         mismatches;
   int         idle_cycles;
   int         burst_left;
   int         stall_run;
   bit         quiet;
   int         stall_pct;
   int         max_gap;

   tdma_shared_bus_arbiter_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Advance the shadow arbiter by one beat and return the reply it owes
   function automatic bus_reply_type arbitrate(input logic mode,
                                               input logic [REQUESTER_W-1:0] rq,
                                               input logic [ADDRESS_W-1:0] addr,
                                               input logic ld);
      bus_reply_type    r;
      region_type       rg;
      logic [3:0]       cnt;
      int               n;
      logic [LAT_W-1:0] lat;
      r   = '0;
      cnt = csr_shadow[CSR_REQ_COUNT][3:0];
      n   = (cnt > SLOTS) ? SLOTS : int'(cnt);
      if (mode == BEAT_TICK) begin
         if (owed[slot_holder] > 0) begin
            owed[slot_holder] = owed[slot_holder] - 1'b1;
         end
         // Slot end: reload, restart an unfinished access, rotate
         if (ticks_left == '0) begin
            ticks_left = csr_shadow[CSR_SLOT_LEN];
            if (n > 1) begin
               if (owed[slot_holder] != REMAIN_IDLE) begin
                  owed[slot_holder] = {1'b0, reload_ticks};
               end
               slot_holder = (slot_holder + 1) % n;
            end
         end
         ticks_left = ticks_left - 1'b1;
      end else begin
         r.busy = 1'b1;
         if (int'(rq) == slot_holder) begin
            if (owed[slot_holder] == 0) begin
               // Collect a finished access
               owed[slot_holder] = REMAIN_IDLE;
               r.busy = 1'b0;
            end else if (owed[slot_holder] == REMAIN_IDLE) begin
               if (addr >= DDR_LO && addr <= DDR_HI) begin
                  rg = REGION_DDR;
               end else if (addr >= ONCHIP_LO && addr <= ONCHIP_HI) begin
                  rg = REGION_ONCHIP;
               end else if (addr >= SRAM_LO && addr <= SRAM_HI) begin
                  rg = REGION_SRAM;
               end else begin
                  rg = REGION_NONE;
               end
               if (rg == REGION_NONE) begin
                  r.unmapped = 1'b1;
               end else begin
                  lat = csr_shadow[(ld ? int'(CSR_LD_DDR) : int'(CSR_ST_DDR)) + int'(rg)];
                  owed[slot_holder] = {1'b0, lat} - 1'b1;
                  reload_ticks = owed[slot_holder][LAT_W-1:0];
               end
            end
         end
      end
      r.owner = slot_holder[REQUESTER_W-1:0];
      return r;
   endfunction

   // Offer one beat, idling between bursts, and log its reply once taken
   task automatic send_beat(input logic mode, input logic [REQUESTER_W-1:0] rq,
                            input logic [ADDRESS_W-1:0] addr, input logic ld);
      int            gap;
      bus_reply_type reply;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = quiet ? 0 : $urandom_range(0, max_gap);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0, ld, addr, rq};
      do @(posedge clock); while (!req_tready);
      reply = arbitrate(mode, rq, addr, ld);
      pending_replies.insert(pending_replies.size(), reply);
   endtask

   task automatic ask_owner(input logic [ADDRESS_W-1:0] addr, input logic ld);
      send_beat(BEAT_QUERY, slot_holder[REQUESTER_W-1:0], addr, ld);
   endtask

   // Drop valid and hold until every reply is back
   task automatic drain_replies;
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the staged values of the registers selected by the mask
   task automatic commit_regs(input logic [7:0] write_mask);
      for (int i = 0; i < 8; i++) begin
         if (write_mask[i]) begin
            csr_wr_en <= 1'b1;
            csr_addr  <= csr_index_type'(i);
            csr_wdata <= staged_regs[i];
            @(posedge clock);
            csr_shadow[i] = staged_regs[i];
         end
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_reset_defaults;
      send_beat(BEAT_TICK, 3'd7, '1, 1'b1);
      send_beat(BEAT_QUERY, 3'd5, DDR_LO, 1'b1);
      ask_owner(32'h7FFF_FFFF, 1'b1);
   endtask

   // Start and collect at every region edge, probe addresses just outside the regions
   task automatic test_address_map;
      logic [ADDRESS_W-1:0] mapped [6];
      logic [ADDRESS_W-1:0] holes [4];
      mapped = '{DDR_LO, DDR_HI, ONCHIP_LO, ONCHIP_HI, SRAM_LO, SRAM_HI};
      holes  = '{DDR_HI + 1, ONCHIP_LO - 1, ONCHIP_HI + 1, SRAM_HI + 1};
      for (int i = 0; i < 6; i++) begin
         ask_owner(mapped[i], i[0]);
         ask_owner(mapped[i], ~i[0]);
      end
      for (int i = 0; i < 4; i++) begin
         ask_owner(holes[i], i[0]);
      end
   endtask

   // Zero slot length, zero latency, counts above the requester limit
   task automatic test_register_extremes;
      drain_replies();
      staged_regs[CSR_REQ_COUNT]  = 16'hFFF9;
      staged_regs[CSR_SLOT_LEN]   = 16'd0;
      staged_regs[CSR_LD_DDR]     = 16'd0;
      staged_regs[CSR_LD_ONCHIP]  = 16'hFFFF;
      staged_regs[CSR_LD_SRAM]    = 16'd2;
      staged_regs[CSR_ST_DDR]     = 16'd1;
      staged_regs[CSR_ST_ONCHIP]  = 16'd3;
      staged_regs[CSR_ST_SRAM]    = 16'hFFFF;
      commit_regs(8'hFF);
      ask_owner(DDR_LO, 1'b1);
      send_beat(BEAT_TICK, 3'd0, 32'd0, 1'b0);
      ask_owner(SRAM_HI, 1'b1);
      repeat (2) send_beat(BEAT_TICK, 3'd2, '1, 1'b1);
      ask_owner(32'd0, 1'b0);
      ask_owner(ONCHIP_HI, 1'b0);
   endtask

   // Park the slot on the last requester, then shrink the rotation under it
   task automatic test_shrink_rotation;
      drain_replies();
      staged_regs[CSR_REQ_COUNT] = 16'd8;
      staged_regs[CSR_SLOT_LEN]  = 16'd1;
      commit_regs(8'h03);
      while (slot_holder != SLOTS - 1) send_beat(BEAT_TICK, 3'd0, 32'd0, 1'b0);
      ask_owner(SRAM_LO, 1'b0);
      drain_replies();
      staged_regs[CSR_REQ_COUNT] = 16'd2;
      commit_regs(8'h01);
      repeat (3) begin
         send_beat(BEAT_TICK, 3'd1, 32'd0, 1'b0);
         ask_owner(ONCHIP_LO, 1'b1);
      end
   endtask

   // Phases of random settings; most queries come from the slot owner
   task automatic test_random_traffic;
      logic [ADDRESS_W-1:0] addr;
      logic [REQUESTER_W-1:0] rq;
      for (int phase = 0; phase < 12; phase++) begin
         drain_replies();
         for (int i = int'(CSR_LD_DDR); i < 8; i++) begin
            case ($urandom_range(0, 15))
               0:       staged_regs[i] = 16'd0;
               1:       staged_regs[i] = 16'hFFFF;
               default: staged_regs[i] = $urandom_range(1, 9);
            endcase
         end
         staged_regs[CSR_REQ_COUNT] = ($urandom_range(0, 3) == 0) ?
                                      16'($urandom) : 16'($urandom_range(2, 8));
         staged_regs[CSR_SLOT_LEN]  = ($urandom_range(0, 9) == 0) ?
                                      16'($urandom) : 16'($urandom_range(0, 12));
         if (phase == 0) begin
            staged_regs[CSR_REQ_COUNT] = 16'h000F;
            for (int i = int'(CSR_SLOT_LEN); i < 8; i++) staged_regs[i] = 16'hFFFF;
         end else if (phase == 1) begin
            for (int i = 0; i < 8; i++) staged_regs[i] = 16'd1;
         end
         commit_regs(8'hFF);
         quiet     = (phase % 4 == 2);
         stall_pct = $urandom_range(0, 60);
         max_gap   = $urandom_range(1, 8);
         for (int k = 0; k < 150; k++) begin
            if ($urandom_range(0, 99) < 45) begin
               send_beat(BEAT_TICK, 3'($urandom), $urandom, 1'($urandom));
            end else begin
               rq = ($urandom_range(0, 3) != 0) ? slot_holder[REQUESTER_W-1:0] : 3'($urandom);
               case ($urandom_range(0, 9))
                  0, 1, 2: addr = DDR_LO + $urandom_range(0, DDR_HI - DDR_LO);
                  3, 4:    addr = ONCHIP_LO + $urandom_range(0, ONCHIP_HI - ONCHIP_LO);
                  5, 6:    addr = SRAM_LO + $urandom_range(0, SRAM_HI - SRAM_LO);
                  7: begin
                     case ($urandom_range(0, 5))
                        0:       addr = DDR_LO - 1;
                        1:       addr = DDR_HI + 1;
                        2:       addr = ONCHIP_LO - 1;
                        3:       addr = ONCHIP_HI + 1;
                        4:       addr = SRAM_LO - 1;
                        default: addr = SRAM_HI + 1;
                     endcase
                  end
                  default: addr = $urandom;
               endcase
               send_beat(BEAT_QUERY, rq, addr, 1'($urandom));
            end
         end
      end
   endtask

   // Receiver: stall in short random runs unless traffic is quiet
   always @(posedge clock) begin
      if (stall_run > 0) begin
         stall_run--;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
         stall_run = $urandom_range(1, 5);
      end
      rsp_tready <= (stall_run == 0);
   end

   // Compare each reply beat with the oldest pending reply
   always @(posedge clock) begin
      bus_reply_type got;
      bus_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[4:0];
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected reply beat: busy=%0b unmapped=%0b owner=%0d",
                        got.busy, got.unmapped, got.owner);
            end
         end else begin
            want = pending_replies.pop_front();
            if (got.busy !== want.busy || got.unmapped !== want.unmapped ||
                got.owner !== want.owner) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("reply mismatch: want busy=%0b unmapped=%0b owner=%0d, %s",
                           want.busy, want.unmapped, want.owner, "got below");
                  $display("   got busy=%0b unmapped=%0b owner=%0d",
                           got.busy, got.unmapped, got.owner);
               end
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("** tdma_shared_bus_arbiter_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = BEAT_TICK;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_addr    = CSR_REQ_COUNT;
      csr_wdata   = '0;
      mismatches  = 0;
      idle_cycles = 0;
      burst_left  = 0;
      stall_run   = 0;
      quiet       = 1'b0;
      stall_pct   = 30;
      max_gap     = 4;
      // Shadow state after reset
      for (int i = 0; i < 8; i++) csr_shadow[i] = 16'd1;
      for (int i = 0; i < 8; i++) staged_regs[i] = 16'd1;
      for (int i = 0; i < SLOTS; i++) owed[i] = REMAIN_IDLE;
      slot_holder  = 0;
      ticks_left   = '0;
      reload_ticks = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Rotate while the slot counter is still short; a zero slot length
      // later leaves it near its top
      test_reset_defaults();
      test_address_map();
      test_shrink_rotation();
      test_register_extremes();
      test_random_traffic();

      drain_replies();
      if (mismatches == 0) begin
         $display("** tdma_shared_bus_arbiter_unit: PASSED **");
      end else begin
         $display("** tdma_shared_bus_arbiter_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/tdma_arb_pkg.sv
rtl/tdma_shared_bus_arbiter_unit.sv
tb/tb_tdma_shared_bus_arbiter_unit.sv
